// ===== rtl/lrs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Linear regression statistics package
// Widths of the sums, the shared multiplier, the accumulator and the shared
// divider, and the default values of the top-level parameters.
// ----------------------------------------------------------------------------
package lrs_pkg;

   localparam int SAMPLE_W = 16;
   localparam int SUM_W    = 32;
   localparam int SQ_W     = 48;
   localparam int RES_W    = 48;
   localparam int MEAN_W   = 32;
   localparam int FRAC_W   = 16;

   localparam int CHUNK_W  = 24;
   localparam int MUL_A_W  = 33;
   localparam int MUL_B_W  = CHUNK_W + 1;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int ACC_W    = PROD_W + CHUNK_W;

   localparam int DIV_W    = 63;
   localparam int DVD_W    = ACC_W + FRAC_W;
   localparam int DCNT_W   = $clog2(DVD_W);

   localparam int MAX_SAMPLES_DEF = 65536;
   localparam int SAMPLE_BITS_DEF = 16;

endpackage
`default_nettype wire

// ===== rtl/linear_regression_stats_core.sv =====
// Words are accepted one per cycle while the core is idle; from a last word
// on, req_stall holds off new words until the set's result is registered.
// The time a set takes is mostly set by the shared restoring divider, which
// retires one quotient bit per cycle over DVD_W bits and runs four times per
// set (twice when the set is degenerate).
// Reset clears the sums, count, extremes and the output valid.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Linear regression statistics core
// Accumulates sums and extremes of (x, y) words and, on the last word of a
// set, computes the least-squares slope, intercept and means with a shared
// multiplier and a shared bit-serial divider under a small sequencer.
// ----------------------------------------------------------------------------
module linear_regression_stats_core
   import lrs_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,

   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic signed [SAMPLE_W-1:0] req_x_value,
   input  wire logic signed [SAMPLE_W-1:0] req_y_value,
   input  wire logic                       req_is_last,

   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic signed [RES_W-1:0]         rsp_slope_q,
   output logic signed [RES_W-1:0]         rsp_intercept_q,
   output logic signed [MEAN_W-1:0]        rsp_mean_x,
   output logic signed [MEAN_W-1:0]        rsp_mean_y,
   output logic signed [SAMPLE_W-1:0]      rsp_min_x,
   output logic signed [SAMPLE_W-1:0]      rsp_max_x,
   output logic signed [SAMPLE_W-1:0]      rsp_min_y,
   output logic signed [SAMPLE_W-1:0]      rsp_max_y,
   output logic                            rsp_degenerate,
   output logic                            rsp_overflow_flag
);

   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int SHIFT = SAMPLE_W - SAMPLE_BITS;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_TOP = SAMPLE_W'((2 ** (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_BOT = SAMPLE_W'(-(2 ** (SAMPLE_BITS - 1)));

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_ACC   = 3'd2;
   localparam logic [2:0] ST_SETUP = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_STORE = 3'd5;
   localparam logic [2:0] ST_FIN   = 3'd6;

   localparam logic [2:0] JOB_DEN   = 3'd0;
   localparam logic [2:0] JOB_SLOPE = 3'd1;
   localparam logic [2:0] JOB_ICPT  = 3'd2;
   localparam logic [2:0] JOB_MX    = 3'd3;
   localparam logic [2:0] JOB_MY    = 3'd4;

   localparam logic [1:0] STEP_LAST = 2'd3;

   logic [2:0]                  state_ff, state_in;
   logic [2:0]                  job_ff, job_in;
   logic [1:0]                  step_ff, step_in;
   logic [DCNT_W-1:0]           dcnt_ff, dcnt_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic signed [SUM_W-1:0]     sum_x_ff, sum_x_in;
   logic signed [SUM_W-1:0]     sum_y_ff, sum_y_in;
   logic signed [SQ_W-1:0]      sum_xy_ff, sum_xy_in;
   logic signed [SQ_W-1:0]      sum_xx_ff, sum_xx_in;
   logic signed [SAMPLE_W-1:0]  low_x_ff, low_x_in;
   logic signed [SAMPLE_W-1:0]  high_x_ff, high_x_in;
   logic signed [SAMPLE_W-1:0]  low_y_ff, low_y_in;
   logic signed [SAMPLE_W-1:0]  high_y_ff, high_y_in;
   logic                        ovf_ff, ovf_in;

   logic signed [PROD_W-1:0]    prod_ff, prod_in;
   logic signed [ACC_W-1:0]     acc_ff, acc_in;
   logic [DIV_W-1:0]            den_ff, den_in;
   logic                        degen_ff, degen_in;
   logic [DIV_W-1:0]            div_ff, div_in;
   logic [DVD_W-1:0]            dq_ff, dq_in;
   logic [DIV_W-1:0]            rem_ff, rem_in;
   logic                        neg_ff, neg_in;
   logic signed [RES_W-1:0]     slope_ff, slope_in;
   logic signed [RES_W-1:0]     icpt_ff, icpt_in;
   logic signed [MEAN_W-1:0]    mean_x_ff, mean_x_in;
   logic signed [MEAN_W-1:0]    mean_y_ff, mean_y_in;

   logic signed [RES_W-1:0]     out_slope_ff, out_slope_in;
   logic signed [RES_W-1:0]     out_icpt_ff, out_icpt_in;
   logic signed [MEAN_W-1:0]    out_mean_x_ff, out_mean_x_in;
   logic signed [MEAN_W-1:0]    out_mean_y_ff, out_mean_y_in;
   logic signed [SAMPLE_W-1:0]  out_min_x_ff, out_min_x_in;
   logic signed [SAMPLE_W-1:0]  out_max_x_ff, out_max_x_in;
   logic signed [SAMPLE_W-1:0]  out_min_y_ff, out_min_y_in;
   logic signed [SAMPLE_W-1:0]  out_max_y_ff, out_max_y_in;
   logic                        out_degen_ff, out_degen_in;
   logic                        out_ovf_ff, out_ovf_in;

   logic signed [SAMPLE_W-1:0]  x_s, y_s;
   logic signed [2*SAMPLE_W-1:0] xx_prod, xy_prod;

   logic signed [MUL_A_W-1:0]   mul_a;
   logic signed [SQ_W-1:0]      opnd_b;
   logic signed [MUL_B_W-1:0]   mul_b;
   logic signed [PROD_W-1:0]    mul_prod;
   logic signed [ACC_W-1:0]     term;
   logic signed [ACC_W-1:0]     acc_sum;
   logic [ACC_W-1:0]            acc_mag;
   logic                        degen_now;
   logic [DIV_W-1:0]            div_sel;
   logic [DVD_W-1:0]            dvd_load;
   logic [DIV_W:0]              rem_sh, rem_diff;
   logic                        rem_ge;
   logic [DIV_W-1:0]            rem_next;
   logic                        is_mean;
   logic [DVD_W-1:0]            lim;
   logic [RES_W-1:0]            sat_res;
   logic                        out_free;

   // Samples are taken from their low SAMPLE_BITS bits, sign-extended.
   assign x_s     = $signed(req_x_value << SHIFT) >>> SHIFT;
   assign y_s     = $signed(req_y_value << SHIFT) >>> SHIFT;
   assign xx_prod = x_s * x_s;
   assign xy_prod = x_s * y_s;

   // Each product job is four steps: two halves of a0*b0 added, then two
   // halves of a1*b1 subtracted.
   always_comb begin
      mul_a  = '0;
      opnd_b = '0;
      case (job_ff)
         JOB_DEN: begin
            if (!step_ff[1]) begin
               mul_a  = MUL_A_W'(cnt_ff);
               opnd_b = sum_xx_ff;
            end else begin
               mul_a  = MUL_A_W'(sum_x_ff);
               opnd_b = SQ_W'(sum_x_ff);
            end
         end
         JOB_SLOPE: begin
            if (!step_ff[1]) begin
               mul_a  = MUL_A_W'(cnt_ff);
               opnd_b = sum_xy_ff;
            end else begin
               mul_a  = MUL_A_W'(sum_x_ff);
               opnd_b = SQ_W'(sum_y_ff);
            end
         end
         JOB_ICPT: begin
            if (!step_ff[1]) begin
               mul_a  = MUL_A_W'(sum_y_ff);
               opnd_b = sum_xx_ff;
            end else begin
               mul_a  = MUL_A_W'(sum_x_ff);
               opnd_b = sum_xy_ff;
            end
         end
         default: begin
            mul_a  = '0;
            opnd_b = '0;
         end
      endcase
   end

   assign mul_b    = step_ff[0] ? {opnd_b[SQ_W-1], opnd_b[SQ_W-1:CHUNK_W]}
                                : {1'b0, opnd_b[CHUNK_W-1:0]};
   assign mul_prod = mul_a * mul_b;
   assign term     = step_ff[0] ? (ACC_W'(prod_ff) <<< CHUNK_W) : ACC_W'(prod_ff);
   assign acc_sum  = step_ff[1] ? (acc_ff - term) : (acc_ff + term);

   assign acc_mag   = acc_ff[ACC_W-1] ? (~acc_ff + ACC_W'(1)) : acc_ff;
   assign degen_now = (acc_ff[ACC_W-1:DIV_W] != '0) || (acc_ff[DIV_W-1:0] == '0);
   assign is_mean   = job_ff inside {JOB_MX, JOB_MY};
   assign div_sel   = (job_ff inside {JOB_SLOPE, JOB_ICPT}) ? den_ff : DIV_W'(cnt_ff);
   assign dvd_load  = {acc_mag, {FRAC_W{1'b0}}} + DVD_W'(div_sel >> 1);

   assign rem_sh   = {rem_ff, dq_ff[DVD_W-1]};
   assign rem_diff = rem_sh - {1'b0, div_ff};
   assign rem_ge   = rem_sh >= {1'b0, div_ff};
   assign rem_next = rem_ge ? rem_diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];

   assign lim = is_mean ? (DVD_W'(1) << (MEAN_W - 1)) : (DVD_W'(1) << (RES_W - 1));

   always_comb begin
      if (neg_ff) begin
         sat_res = (dq_ff > lim) ? RES_W'(DVD_W'(0) - lim) : RES_W'(DVD_W'(0) - dq_ff);
      end else begin
         sat_res = (dq_ff >= lim) ? RES_W'(lim - DVD_W'(1)) : RES_W'(dq_ff);
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      step_in       = step_ff;
      dcnt_in       = dcnt_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      cnt_in        = cnt_ff;
      sum_x_in      = sum_x_ff;
      sum_y_in      = sum_y_ff;
      sum_xy_in     = sum_xy_ff;
      sum_xx_in     = sum_xx_ff;
      low_x_in      = low_x_ff;
      high_x_in     = high_x_ff;
      low_y_in      = low_y_ff;
      high_y_in     = high_y_ff;
      ovf_in        = ovf_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      den_in        = den_ff;
      degen_in      = degen_ff;
      div_in        = div_ff;
      dq_in         = dq_ff;
      rem_in        = rem_ff;
      neg_in        = neg_ff;
      slope_in      = slope_ff;
      icpt_in       = icpt_ff;
      mean_x_in     = mean_x_ff;
      mean_y_in     = mean_y_ff;
      out_slope_in  = out_slope_ff;
      out_icpt_in   = out_icpt_ff;
      out_mean_x_in = out_mean_x_ff;
      out_mean_y_in = out_mean_y_ff;
      out_min_x_in  = out_min_x_ff;
      out_max_x_in  = out_max_x_ff;
      out_min_y_in  = out_min_y_ff;
      out_max_y_in  = out_max_y_ff;
      out_degen_in  = out_degen_ff;
      out_ovf_in    = out_ovf_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (cnt_ff >= CNT_W'(MAX_SAMPLES)) begin
                  ovf_in = 1'b1;
               end else begin
                  cnt_in    = cnt_ff + CNT_W'(1);
                  sum_x_in  = sum_x_ff + SUM_W'(x_s);
                  sum_y_in  = sum_y_ff + SUM_W'(y_s);
                  sum_xy_in = sum_xy_ff + SQ_W'(xy_prod);
                  sum_xx_in = sum_xx_ff + SQ_W'(xx_prod);
                  if (x_s < low_x_ff) low_x_in = x_s;
                  if (x_s > high_x_ff) high_x_in = x_s;
                  if (y_s < low_y_ff) low_y_in = y_s;
                  if (y_s > high_y_ff) high_y_in = y_s;
               end
               if (req_is_last) begin
                  state_in = ST_MUL;
                  job_in   = JOB_DEN;
                  step_in  = '0;
                  acc_in   = '0;
               end
            end
         end
         ST_MUL: begin
            prod_in  = mul_prod;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in = acc_sum;
            if (step_ff == STEP_LAST) begin
               state_in = ST_SETUP;
            end else begin
               step_in  = step_ff + 2'd1;
               state_in = ST_MUL;
            end
         end
         ST_SETUP: begin
            if (job_ff == JOB_DEN) begin
               den_in   = acc_ff[DIV_W-1:0];
               degen_in = degen_now;
               if (degen_now) begin
                  slope_in = '0;
                  icpt_in  = '0;
                  job_in   = JOB_MX;
                  acc_in   = ACC_W'(sum_x_ff);
               end else begin
                  job_in   = JOB_SLOPE;
                  acc_in   = '0;
                  step_in  = '0;
                  state_in = ST_MUL;
               end
            end else begin
               div_in   = div_sel;
               dq_in    = dvd_load;
               rem_in   = '0;
               neg_in   = acc_ff[ACC_W-1];
               dcnt_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            dq_in   = {dq_ff[DVD_W-2:0], rem_ge};
            rem_in  = rem_next;
            dcnt_in = dcnt_ff + DCNT_W'(1);
            if (dcnt_ff == DCNT_W'(DVD_W - 1)) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            case (job_ff)
               JOB_SLOPE: begin
                  slope_in = sat_res;
                  job_in   = JOB_ICPT;
                  acc_in   = '0;
                  step_in  = '0;
                  state_in = ST_MUL;
               end
               JOB_ICPT: begin
                  icpt_in  = sat_res;
                  job_in   = JOB_MX;
                  acc_in   = ACC_W'(sum_x_ff);
                  state_in = ST_SETUP;
               end
               JOB_MX: begin
                  mean_x_in = sat_res[MEAN_W-1:0];
                  job_in    = JOB_MY;
                  acc_in    = ACC_W'(sum_y_ff);
                  state_in  = ST_SETUP;
               end
               JOB_MY: begin
                  mean_y_in = sat_res[MEAN_W-1:0];
                  state_in  = ST_FIN;
               end
               default: begin
                  state_in = ST_FIN;
               end
            endcase
         end
         ST_FIN: begin
            if (out_free) begin
               out_slope_in  = slope_ff;
               out_icpt_in   = icpt_ff;
               out_mean_x_in = mean_x_ff;
               out_mean_y_in = mean_y_ff;
               out_min_x_in  = low_x_ff;
               out_max_x_in  = high_x_ff;
               out_min_y_in  = low_y_ff;
               out_max_y_in  = high_y_ff;
               out_degen_in  = degen_ff;
               out_ovf_in    = ovf_ff;
               rsp_valid_in  = 1'b1;
               cnt_in        = '0;
               sum_x_in      = '0;
               sum_y_in      = '0;
               sum_xy_in     = '0;
               sum_xx_in     = '0;
               low_x_in      = SAMPLE_TOP;
               high_x_in     = SAMPLE_BOT;
               low_y_in      = SAMPLE_TOP;
               high_y_in     = SAMPLE_BOT;
               ovf_in        = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         job_ff       <= JOB_DEN;
         step_ff      <= '0;
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         sum_xy_ff    <= '0;
         sum_xx_ff    <= '0;
         low_x_ff     <= SAMPLE_TOP;
         high_x_ff    <= SAMPLE_BOT;
         low_y_ff     <= SAMPLE_TOP;
         high_y_ff    <= SAMPLE_BOT;
         ovf_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         job_ff       <= job_in;
         step_ff      <= step_in;
         dcnt_ff      <= dcnt_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         sum_x_ff     <= sum_x_in;
         sum_y_ff     <= sum_y_in;
         sum_xy_ff    <= sum_xy_in;
         sum_xx_ff    <= sum_xx_in;
         low_x_ff     <= low_x_in;
         high_x_ff    <= high_x_in;
         low_y_ff     <= low_y_in;
         high_y_ff    <= high_y_in;
         ovf_ff       <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      den_ff        <= den_in;
      degen_ff      <= degen_in;
      div_ff        <= div_in;
      dq_ff         <= dq_in;
      rem_ff        <= rem_in;
      neg_ff        <= neg_in;
      slope_ff      <= slope_in;
      icpt_ff       <= icpt_in;
      mean_x_ff     <= mean_x_in;
      mean_y_ff     <= mean_y_in;
      out_slope_ff  <= out_slope_in;
      out_icpt_ff   <= out_icpt_in;
      out_mean_x_ff <= out_mean_x_in;
      out_mean_y_ff <= out_mean_y_in;
      out_min_x_ff  <= out_min_x_in;
      out_max_x_ff  <= out_max_x_in;
      out_min_y_ff  <= out_min_y_in;
      out_max_y_ff  <= out_max_y_in;
      out_degen_ff  <= out_degen_in;
      out_ovf_ff    <= out_ovf_in;
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_slope_q       = out_slope_ff;
   assign rsp_intercept_q   = out_icpt_ff;
   assign rsp_mean_x        = out_mean_x_ff;
   assign rsp_mean_y        = out_mean_y_ff;
   assign rsp_min_x         = out_min_x_ff;
   assign rsp_max_x         = out_max_x_ff;
   assign rsp_min_y         = out_min_y_ff;
   assign rsp_max_y         = out_max_y_ff;
   assign rsp_degenerate    = out_degen_ff;
   assign rsp_overflow_flag = out_ovf_ff;

   // A word that closes a set always starts the computation.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_is_last) |=> (state_ff == ST_MUL))
      else $error("Last word did not start the computation.");

   // The partial remainder stays below the divisor throughout a division.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < div_ff))
      else $error("Divider remainder reached the divisor.");

   // A degenerate set reports a zero slope and intercept.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |-> (rsp_slope_q == '0 && rsp_intercept_q == '0))
      else $error("Degenerate result carries a nonzero fit.");

   // Every set holds at least one counted pair, so the extremes are ordered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_min_x <= rsp_max_x && rsp_min_y <= rsp_max_y))
      else $error("Reported extremes are out of order.");

endmodule
`default_nettype wire
